// ===== rtl/tdp_pkg.sv =====
// Shared types for the trial division primality core.
`default_nettype none

package tdp_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
    logic div_le_quo;
  } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/trial_division_primality_core.sv =====
// Top level: trial division primality tester over odd divisors with a serial divider.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   input   | in_valid, in_ready, number   | in
//   output  | out_valid, out_ready, is_prime | out
//
// Values below 4 and even values skip the divider. Otherwise each odd
// divisor from 3 is tried in the serial divider until one divides the word
// evenly or exceeds the quotient, which shows that the word is prime.
// One word is worked at a time; a result waits in the output register while
// out_ready is low and the next word is taken once it has been loaded there.
// Reset clears the state machine and the output valid.
`default_nettype none

module trial_division_primality_core #(
  parameter int NUMBER_BITS = 31
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [NUMBER_BITS-1:0] number,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   is_prime
);

  localparam logic [NUMBER_BITS-1:0] FIRST_DIV = NUMBER_BITS'(3);
  localparam logic [NUMBER_BITS-1:0] DIV_STEP  = NUMBER_BITS'(2);

  tdp_pkg::state_t        state, state_next;
  logic [NUMBER_BITS-1:0] n, n_next;
  logic [NUMBER_BITS-1:0] d, d_next;
  logic                   res, res_next;
  logic                   out_valid_next;
  logic                   is_prime_next;

  logic                   div_start;
  logic [NUMBER_BITS-1:0] div_dividend;
  tdp_pkg::div_status_t   div_status;

  tdp_divider #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (d_next),
    .status   (div_status)
  );

  always_comb begin
    state_next     = state;
    n_next         = n;
    d_next         = d;
    res_next       = res;
    out_valid_next = out_valid;
    is_prime_next  = is_prime;
    in_ready       = 1'b0;
    div_start      = 1'b0;
    div_dividend   = n;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      tdp_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        div_dividend = number;
        if (in_valid) begin
          n_next = number;
          if (number[NUMBER_BITS-1:1] == '0) begin
            res_next   = 1'b0;
            state_next = tdp_pkg::S_OUT;
          end else if (number[NUMBER_BITS-1:2] == '0) begin
            res_next   = 1'b1;
            state_next = tdp_pkg::S_OUT;
          end else if (!number[0]) begin
            res_next   = 1'b0;
            state_next = tdp_pkg::S_OUT;
          end else begin
            d_next     = FIRST_DIV;
            div_start  = 1'b1;
            state_next = tdp_pkg::S_DIV;
          end
        end
      end
      tdp_pkg::S_DIV: begin
        if (div_status.done) begin
          priority if (!div_status.div_le_quo) begin
            res_next   = 1'b1;
            state_next = tdp_pkg::S_OUT;
          end else if (div_status.rem_zero) begin
            res_next   = 1'b0;
            state_next = tdp_pkg::S_OUT;
          end else begin
            d_next    = d + DIV_STEP;
            div_start = 1'b1;
          end
        end
      end
      tdp_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          is_prime_next  = res;
          state_next     = tdp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tdp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n        <= n_next;
    d        <= d_next;
    res      <= res_next;
    is_prime <= is_prime_next;
  end

endmodule

`default_nettype wire

// ===== rtl/tdp_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, with end-of-division flags.
`default_nettype none

module tdp_divider #(
  parameter int NUMBER_BITS = 31
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire  [NUMBER_BITS-1:0]   dividend,
  input  wire  [NUMBER_BITS-1:0]   divisor,
  output tdp_pkg::div_status_t     status
);

  localparam int CW = $clog2(NUMBER_BITS);
  localparam logic [CW-1:0] LAST = CW'(NUMBER_BITS - 1);

  logic                   busy;
  logic                   done;
  logic [CW-1:0]          cnt;
  logic [NUMBER_BITS-1:0] rem;
  logic [NUMBER_BITS-1:0] quo;
  logic [NUMBER_BITS-1:0] dvs;

  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   diff;
  logic                   ge;
  logic [NUMBER_BITS-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NUMBER_BITS-1]};
    ge       = trial >= {1'b0, dvs};
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= LAST;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NUMBER_BITS-2:0], ge};
    end
  end

  assign status.done       = done;
  assign status.rem_zero   = (rem == '0);
  assign status.div_le_quo = (dvs <= quo);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for trial_division_primality_core: mixed directed and random words.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUMBER_BITS = 31;
  localparam int STALL_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 64;

  typedef logic [NUMBER_BITS-1:0] number_t;

  class prime_scoreboard;
    typedef struct {
      number_t number;
      bit      prime;
    } verdict_t;

    verdict_t verdicts[$];
    int       errors;
    int       words_in;
    int       words_checked;

    function bit prime_by_division(number_t n);
      longint unsigned v;
      longint unsigned d;
      v = n;
      if (v < 2) return 1'b0;
      if (v < 4) return 1'b1;
      if (v % 2 == 0) return 1'b0;
      for (d = 3; d * d <= v; d += 2) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(number_t n);
      verdict_t v;
      v.number = n;
      v.prime  = prime_by_division(n);
      verdicts.push_back(v);
      words_in++;
    endfunction

    function void check_word(logic prime);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual is_prime=%0b",
                 $time, prime);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      words_checked++;
      if (prime !== v.prime) begin
        $display("%0t: is_prime mismatch for number %0d: expected %0b, actual %0b",
                 $time, v.number, v.prime, prime);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  number_t number = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    is_prime;

  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  prime_scoreboard sb = new();

  always #5 clk = ~clk;

  trial_division_primality_core #(
    .NUMBER_BITS(NUMBER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .number(number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_prime(is_prime)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_word(is_prime);
      if (in_valid && in_ready) sb.note_word(number);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input number_t n);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic number_t random_number();
    int unsigned pick;
    int unsigned k;
    number_t     r;
    pick = $urandom_range(99);
    r    = $urandom;
    if (pick < 50) begin
      return number_t'($urandom_range(4095));
    end else if (pick < 92) begin
      // full-width value with a small factor keeps the divisor search short
      case ($urandom_range(5))
        0: k = 2;
        1: k = 3;
        2: k = 5;
        3: k = 7;
        4: k = 11;
        default: k = 13;
      endcase
      return number_t'(r - (r % k));
    end else begin
      return number_t'($urandom_range(262143));
    end
  endfunction

  task automatic run_random(input int idle, input int stall, input int count);
    send_idle  = idle;
    recv_stall = stall;
    repeat (count) send_word(random_number());
  endtask

  number_t directed[$];

  initial begin
    directed = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd9, 31'd25, 31'd49, 31'd97,
      31'd65521, 31'd65535, 31'd1000003, 31'd16752649, 31'd63001,
      31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555,
      31'h7FFF_FFFE, 31'h7FFF_FFFD, 31'h7FFF_FFFF
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i]);

    run_random(0, 0, 25);
    run_random(80, 0, 25);
    run_random(0, 80, 25);
    run_random(36, 36, 25);
    in_valid <= 1'b0;
    recv_stall = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d directed), checked %0d verdicts, %0d errors.",
             sb.words_in, directed.size(), sb.words_checked, sb.errors);
    $display("Idle/stall phases: none, sender 80%%, receiver 80%%, both 36%%.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
